@@ src/fwur_pkg.sv @@
// Package with constants, types and the CRC-32 byte update for the update receiver.
`timescale 1ns / 1ps
`default_nettype none
package fwur_pkg;

    localparam int CHUNK_MAX_DEFAULT = 200;
    localparam logic [24:0] PARTITION_LIMIT_RESET = 25'd1048576;
    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;

    typedef enum logic [2:0] {
        CMD_BEGIN   = 3'd0,
        CMD_HEADER  = 3'd1,
        CMD_PAYLOAD = 3'd2,
        CMD_END     = 3'd3,
        CMD_ABORT   = 3'd4
    } command_t;

    typedef enum logic [2:0] {
        ST_READY       = 3'd0,
        ST_DATA_OK     = 3'd1,
        ST_DUP         = 3'd2,
        ST_COMPLETE    = 3'd3,
        ST_BAD_SESSION = 3'd4,
        ST_BAD_SEQ     = 3'd5,
        ST_BAD_SIZE    = 3'd6,
        ST_BAD_CRC     = 3'd7
    } status_t;

    typedef struct packed {
        logic [24:0] bytes_done;
        logic [31:0] ack_session;
        logic [31:0] expected_seq;
        logic [31:0] ack_seq;
        logic [2:0]  ack_status;
    } ack_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage
`default_nettype wire

@@ src/fwur_crc_unit.sv @@
// Per-chunk and tentative image CRC-32 byte updates.
`timescale 1ns / 1ps
`default_nettype none
module fwur_crc_unit
(
    input  wire logic [31:0] chunk_crc,
    input  wire logic [31:0] image_crc,
    input  wire logic [7:0]  data,
    output logic [31:0]      chunk_crc_new,
    output logic [31:0]      image_crc_new
);
    assign chunk_crc_new = fwur_pkg::crc_byte(chunk_crc, data);
    assign image_crc_new = fwur_pkg::crc_byte(image_crc, data);
endmodule
`default_nettype wire

@@ src/firmware_update_session_receiver_unit.sv @@
// Top level of the firmware update session receiver.
//   channel | direction | contents
//   s_axis  | in        | tuser: command; tdata: session_tag, packet_seq, image_bytes,
//           |           |        image_check, chunk_len, chunk_check, payload_byte;
//           |           | tlast: byte_last
//   m_axis  | out       | tdata: ack_status, ack_seq, expected_seq, ack_session, bytes_done
//   cfg     | in        | partition_limit
// One item is taken per cycle while the input is ready, that is whenever the output
// register is empty or being drained; an ack it yields is registered the cycle after.
// Reset clears the session, the pending chunk and sets partition_limit to 1048576.
// The CRC byte update sets the longest path.
`timescale 1ns / 1ps
`default_nettype none
module firmware_update_session_receiver_unit
#(
    parameter int CHUNK_MAX = fwur_pkg::CHUNK_MAX_DEFAULT
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // session_tag[31:0], packet_seq[63:32], image_bytes[88:64], image_check[120:89],
    // chunk_len[128:121], chunk_check[160:129], payload_byte[168:161]
    input  wire logic [175:0] s_axis_tdata,
    // command[2:0]
    input  wire logic [2:0]   s_axis_tuser,
    input  wire logic         s_axis_tlast,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // ack_status[2:0], ack_seq[34:3], expected_seq[66:35], ack_session[98:67],
    // bytes_done[123:99]
    output logic [127:0]      m_axis_tdata,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [24:0]  cfg_data
);
    logic [2:0]  command;
    logic [31:0] session_tag, packet_seq, image_check, chunk_check;
    logic [24:0] image_bytes;
    logic [7:0]  chunk_len, payload_byte;

    assign command      = s_axis_tuser;
    assign session_tag  = s_axis_tdata[31:0];
    assign packet_seq   = s_axis_tdata[63:32];
    assign image_bytes  = s_axis_tdata[88:64];
    assign image_check  = s_axis_tdata[120:89];
    assign chunk_len    = s_axis_tdata[128:121];
    assign chunk_check  = s_axis_tdata[160:129];
    assign payload_byte = s_axis_tdata[168:161];

    logic [24:0] limit_reg;
    logic        open_reg, open_next;
    logic [31:0] sess_reg, sess_next, exp_reg, exp_next, icrc_val_reg, icrc_val_next;
    logic [24:0] isize_reg, isize_next, done_reg, done_next;
    logic [31:0] irun_reg, irun_next, itent_reg, itent_next, crun_reg, crun_next;
    logic [31:0] lseq_reg, lseq_next, lcrc_reg, lcrc_next;
    logic [7:0]  llen_reg, llen_next, cnt_reg, cnt_next;
    logic        pend_reg, pend_next;
    logic        out_valid_reg, out_valid_next;
    fwur_pkg::ack_t out_reg, out_next;

    logic        take;
    logic [31:0] crc_c, crc_i;
    logic [7:0]  cnt_inc;
    logic        match;
    logic [25:0] hdr_sum;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign take          = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'd0, out_reg};

    fwur_crc_unit u_crc
    (
        .chunk_crc     (crun_reg),
        .image_crc     (itent_reg),
        .data          (payload_byte),
        .chunk_crc_new (crc_c),
        .image_crc_new (crc_i)
    );

    assign match   = open_reg && (sess_reg == session_tag);
    assign cnt_inc = cnt_reg + 8'd1;
    assign hdr_sum = {1'b0, done_reg} + {18'd0, chunk_len};

    always_comb
    begin
        logic emit;
        logic [2:0] st;
        logic [31:0] aseq, asess, nseq;
        logic close, drop;
        emit = 1'b0; st = fwur_pkg::ST_READY; aseq = packet_seq; asess = sess_reg;
        nseq = exp_reg; close = 1'b0; drop = 1'b0;
        open_next = open_reg; sess_next = sess_reg; exp_next = exp_reg;
        icrc_val_next = icrc_val_reg; isize_next = isize_reg; done_next = done_reg;
        irun_next = irun_reg; itent_next = itent_reg; crun_next = crun_reg;
        lseq_next = lseq_reg; lcrc_next = lcrc_reg; llen_next = llen_reg;
        cnt_next = cnt_reg; pend_next = pend_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_next = out_reg;
        if (take)
        begin
            unique case (command)
                fwur_pkg::CMD_PAYLOAD:
                begin
                    if (pend_reg)
                    begin
                        crun_next = crc_c; itent_next = crc_i; cnt_next = cnt_inc;
                        if (s_axis_tlast || cnt_inc == llen_reg)
                        begin
                            emit = 1'b1; aseq = lseq_reg; drop = 1'b1;
                            if (cnt_inc != llen_reg)
                                st = fwur_pkg::ST_BAD_SIZE;
                            else if ((crc_c ^ fwur_pkg::CRC_ONES) != lcrc_reg)
                                st = fwur_pkg::ST_BAD_CRC;
                            else
                            begin
                                st = fwur_pkg::ST_DATA_OK;
                                irun_next = crc_i;
                                done_next = done_reg + {17'd0, llen_reg};
                                exp_next = exp_reg + 32'd1;
                                nseq = exp_reg + 32'd1;
                            end
                        end
                    end
                end
                fwur_pkg::CMD_BEGIN:
                begin
                    drop = 1'b1; emit = 1'b1; aseq = '0; st = fwur_pkg::ST_READY;
                    if (!match)
                    begin
                        close = 1'b1; nseq = '0;
                        if (image_bytes == '0 || image_bytes > limit_reg)
                        begin
                            st = fwur_pkg::ST_BAD_SIZE; asess = session_tag;
                        end
                        else
                        begin
                            asess = session_tag;
                        end
                    end
                end
                fwur_pkg::CMD_HEADER:
                begin
                    drop = 1'b1; emit = 1'b1;
                    if (!match)
                        st = fwur_pkg::ST_BAD_SESSION;
                    else if (packet_seq < exp_reg)
                        st = fwur_pkg::ST_DUP;
                    else if (packet_seq != exp_reg)
                        st = fwur_pkg::ST_BAD_SEQ;
                    else if (chunk_len == '0 || int'(chunk_len) > CHUNK_MAX)
                        st = fwur_pkg::ST_BAD_SIZE;
                    else if (hdr_sum > {1'b0, isize_reg})
                        st = fwur_pkg::ST_BAD_SIZE;
                    else
                        emit = 1'b0;
                end
                fwur_pkg::CMD_END:
                begin
                    drop = 1'b1; emit = 1'b1;
                    if (!match)
                        st = fwur_pkg::ST_BAD_SESSION;
                    else if (done_reg != isize_reg)
                        st = fwur_pkg::ST_BAD_SIZE;
                    else
                    begin
                        close = 1'b1;
                        st = ((irun_reg ^ fwur_pkg::CRC_ONES) != icrc_val_reg)
                            ? fwur_pkg::ST_BAD_CRC : fwur_pkg::ST_COMPLETE;
                    end
                end
                fwur_pkg::CMD_ABORT:
                begin
                    drop = 1'b1; close = match;
                end
                default:
                begin
                end
            endcase
            if (drop)
            begin
                pend_next = 1'b0; cnt_next = '0; crun_next = fwur_pkg::CRC_ONES;
                itent_next = '0; lseq_next = '0; llen_next = '0; lcrc_next = '0;
            end
            if (command == fwur_pkg::CMD_HEADER && match && !emit)
            begin
                lseq_next = packet_seq; llen_next = chunk_len; lcrc_next = chunk_check;
                pend_next = 1'b1; itent_next = irun_reg;
            end
            if (close)
            begin
                open_next = 1'b0; sess_next = '0; exp_next = '0; isize_next = '0;
                icrc_val_next = '0; done_next = '0; irun_next = '0;
            end
            if (command == fwur_pkg::CMD_BEGIN && !match && st == fwur_pkg::ST_READY)
            begin
                open_next = 1'b1; sess_next = session_tag; isize_next = image_bytes;
                icrc_val_next = image_check; irun_next = fwur_pkg::CRC_ONES;
            end
            if (emit)
            begin
                out_valid_next = 1'b1;
                out_next.ack_status   = st;
                out_next.ack_seq      = aseq;
                out_next.expected_seq = nseq;
                out_next.ack_session  = asess;
                out_next.bytes_done   = (command == fwur_pkg::CMD_BEGIN && !match)
                                        ? 25'd0 : done_next;
                if (command == fwur_pkg::CMD_END)
                    out_next.bytes_done = done_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= fwur_pkg::PARTITION_LIMIT_RESET;
            open_reg <= 1'b0; sess_reg <= '0; exp_reg <= '0; icrc_val_reg <= '0;
            isize_reg <= '0; done_reg <= '0; irun_reg <= '0; itent_reg <= '0;
            crun_reg <= fwur_pkg::CRC_ONES; lseq_reg <= '0; lcrc_reg <= '0;
            llen_reg <= '0; cnt_reg <= '0; pend_reg <= 1'b0; out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                limit_reg <= cfg_data;
            open_reg <= open_next; sess_reg <= sess_next; exp_reg <= exp_next;
            icrc_val_reg <= icrc_val_next; isize_reg <= isize_next; done_reg <= done_next;
            irun_reg <= irun_next; itent_reg <= itent_next; crun_reg <= crun_next;
            lseq_reg <= lseq_next; lcrc_reg <= lcrc_next; llen_reg <= llen_next;
            cnt_reg <= cnt_next; pend_reg <= pend_next; out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end
endmodule
`default_nettype wire

@@ tb/fwur_ack_checker.sv @@
// Checker that predicts the acknowledgements of the update receiver and compares them.
`timescale 1ns / 1ps
`default_nettype none
module fwur_ack_checker
    import fwur_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    input  wire logic         s_axis_tready,
    input  wire logic [175:0] s_axis_tdata,
    input  wire logic [2:0]   s_axis_tuser,
    input  wire logic         s_axis_tlast,
    input  wire logic         m_axis_tvalid,
    input  wire logic         m_axis_tready,
    input  wire logic [127:0] m_axis_tdata,
    input  wire logic         cfg_valid,
    input  wire logic         cfg_ready,
    input  wire logic [24:0]  cfg_data,
    output int                acks_pending,
    output int                mismatches
);

    localparam int CHUNK_LIMIT = CHUNK_MAX_DEFAULT;

    ack_t        ack_queue [$];
    logic [24:0] limit_bytes = PARTITION_LIMIT_RESET;
    logic        sess_open = 1'b0;
    logic [31:0] sess_tag = '0;
    logic [31:0] want_seq = '0;
    logic [24:0] image_len = '0;
    logic [31:0] image_sum = '0;
    logic [24:0] done_bytes = '0;
    logic [31:0] image_run = '0;
    logic [31:0] image_tent = '0;
    logic [31:0] chunk_run = CRC_ONES;
    logic [31:0] hold_seq = '0;
    logic [7:0]  hold_len = '0;
    logic [31:0] hold_sum = '0;
    logic [7:0]  got_bytes = '0;
    logic        chunk_open = 1'b0;

    initial
    begin
        acks_pending = 0;
        mismatches = 0;
    end

    function automatic logic [31:0] crc_step(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ 32'hEDB88320;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    task automatic push_ack(input status_t st, input logic [31:0] seq, input logic [31:0] tag);
        ack_t a;
        a.ack_status = st;
        a.ack_seq = seq;
        a.expected_seq = want_seq;
        a.ack_session = tag;
        a.bytes_done = done_bytes;
        ack_queue.push_back(a);
    endtask

    task automatic close_session();
        sess_open = 1'b0;
        sess_tag = '0;
        want_seq = '0;
        image_len = '0;
        image_sum = '0;
        done_bytes = '0;
        image_run = '0;
    endtask

    task automatic discard_chunk();
        chunk_open = 1'b0;
        got_bytes = '0;
        chunk_run = CRC_ONES;
        image_tent = '0;
        hold_seq = '0;
        hold_len = '0;
        hold_sum = '0;
    endtask

    task automatic predict_item(input logic [175:0] d, input logic [2:0] kind,
                                input logic last);
        logic [2:0]  cmd;
        logic [31:0] tag;
        logic [31:0] seq;
        logic [24:0] isize;
        logic [31:0] icrc;
        logic [7:0]  clen;
        logic [31:0] ccrc;
        logic [7:0]  pbyte;
        logic        hit;
        cmd = kind;
        tag = d[31:0];
        seq = d[63:32];
        isize = d[88:64];
        icrc = d[120:89];
        clen = d[128:121];
        ccrc = d[160:129];
        pbyte = d[168:161];
        hit = sess_open && (sess_tag == tag);
        if (cmd > CMD_ABORT)
            return;
        if (cmd == CMD_PAYLOAD)
        begin
            if (!chunk_open)
                return;
            chunk_run = crc_step(chunk_run, pbyte);
            image_tent = crc_step(image_tent, pbyte);
            got_bytes = got_bytes + 8'd1;
            if (!last && got_bytes != hold_len)
                return;
            if (got_bytes != hold_len)
                push_ack(ST_BAD_SIZE, hold_seq, sess_tag);
            else if ((chunk_run ^ CRC_ONES) != hold_sum)
                push_ack(ST_BAD_CRC, hold_seq, sess_tag);
            else
            begin
                image_run = image_tent;
                done_bytes = done_bytes + {17'd0, hold_len};
                want_seq = want_seq + 32'd1;
                push_ack(ST_DATA_OK, hold_seq, sess_tag);
            end
            discard_chunk();
            return;
        end
        discard_chunk();
        case (cmd)
            CMD_BEGIN:
            begin
                if (hit)
                    push_ack(ST_READY, '0, sess_tag);
                else
                begin
                    close_session();
                    if (isize == '0 || isize > limit_bytes)
                        push_ack(ST_BAD_SIZE, '0, tag);
                    else
                    begin
                        sess_open = 1'b1;
                        sess_tag = tag;
                        image_len = isize;
                        image_sum = icrc;
                        image_run = CRC_ONES;
                        push_ack(ST_READY, '0, sess_tag);
                    end
                end
            end
            CMD_HEADER:
            begin
                if (!hit)
                    push_ack(ST_BAD_SESSION, seq, sess_tag);
                else if (seq < want_seq)
                    push_ack(ST_DUP, seq, sess_tag);
                else if (seq != want_seq)
                    push_ack(ST_BAD_SEQ, seq, sess_tag);
                else if (clen == '0 || clen > CHUNK_LIMIT)
                    push_ack(ST_BAD_SIZE, seq, sess_tag);
                else if ({1'b0, done_bytes} + {18'd0, clen} > {1'b0, image_len})
                    push_ack(ST_BAD_SIZE, seq, sess_tag);
                else
                begin
                    hold_seq = seq;
                    hold_len = clen;
                    hold_sum = ccrc;
                    got_bytes = '0;
                    chunk_run = CRC_ONES;
                    image_tent = image_run;
                    chunk_open = 1'b1;
                end
            end
            CMD_END:
            begin
                if (!hit)
                    push_ack(ST_BAD_SESSION, seq, sess_tag);
                else if (done_bytes != image_len)
                    push_ack(ST_BAD_SIZE, seq, sess_tag);
                else
                begin
                    if ((image_run ^ CRC_ONES) != image_sum)
                        push_ack(ST_BAD_CRC, seq, sess_tag);
                    else
                        push_ack(ST_COMPLETE, seq, sess_tag);
                    close_session();
                end
            end
            default:
            begin
                if (hit)
                    close_session();
            end
        endcase
    endtask

    always @(posedge clk)
    begin
        ack_t got;
        ack_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[123:0];
                if (ack_queue.size() == 0)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("unexpected ack: status %0d seq %h next %h session %h bytes %0d",
                                 got.ack_status, got.ack_seq, got.expected_seq, got.ack_session,
                                 got.bytes_done);
                end
                else
                begin
                    want = ack_queue.pop_front();
                    if (got.ack_status != want.ack_status || got.ack_seq != want.ack_seq ||
                        got.expected_seq != want.expected_seq ||
                        got.ack_session != want.ack_session ||
                        got.bytes_done != want.bytes_done)
                    begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("ack mismatch: expected %0d/%h/%h/%h/%0d got %0d/%h/%h/%h/%0d",
                                     want.ack_status, want.ack_seq, want.expected_seq,
                                     want.ack_session, want.bytes_done, got.ack_status,
                                     got.ack_seq, got.expected_seq, got.ack_session,
                                     got.bytes_done);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                limit_bytes = cfg_data;
            if (s_axis_tvalid && s_axis_tready)
                predict_item(s_axis_tdata, s_axis_tuser, s_axis_tlast);
            acks_pending <= ack_queue.size();
        end
    end

endmodule
`default_nettype wire

@@ tb/tb_firmware_update_session_receiver_unit.sv @@
// Testbench top that drives image transfers into the update receiver and reports the verdict.
`timescale 1ns / 1ps
`default_nettype none
module tb_firmware_update_session_receiver_unit;
    import fwur_pkg::*;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [175:0] s_axis_tdata = '0;
    logic [2:0]   s_axis_tuser = '0;
    logic         s_axis_tlast = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [127:0] m_axis_tdata;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [24:0]  cfg_data = '0;
    int           acks_pending;
    int           mismatches;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    int           items_sent = 0;
    logic [24:0]  cur_limit = PARTITION_LIMIT_RESET;
    logic [7:0]   image [0:255];

    always #5 clk = ~clk;

    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

    firmware_update_session_receiver_unit dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    fwur_ack_checker u_checker
    (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .acks_pending(acks_pending),
        .mismatches(mismatches)
    );

    function automatic logic [31:0] crc_over(input logic [31:0] c_in, input int first,
                                             input int count);
        logic [31:0] c;
        c = c_in;
        for (int i = first; i < first + count; i++)
        begin
            c = c ^ {24'd0, image[i]};
            for (int k = 0; k < 8; k++)
                c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
        end
        return c;
    endfunction

    task automatic send(input command_t cmd, input logic [31:0] tag, input logic [31:0] seq,
                        input logic [24:0] isize, input logic [31:0] icrc,
                        input logic [7:0] clen, input logic [31:0] ccrc,
                        input logic [7:0] pbyte, input logic last);
        logic hs;
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {7'd0, pbyte, ccrc, clen, icrc, isize, seq, tag};
        s_axis_tuser <= cmd;
        s_axis_tlast <= last;
        do
        begin
            @(negedge clk);
            hs = s_axis_tready;
            @(posedge clk);
        end
        while (!hs);
        items_sent++;
    endtask

    task automatic send_noise(input logic [31:0] tag);
        logic [2:0] cmd;
        cmd = 3'($urandom_range(7));
        send(command_t'(cmd), ($urandom_range(1) == 0) ? tag : $urandom(), $urandom(),
             25'($urandom()), $urandom(), 8'($urandom()), $urandom(), 8'($urandom()),
             1'($urandom_range(1)));
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (acks_pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_limit(input logic [24:0] v);
        logic hs;
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do
        begin
            @(negedge clk);
            hs = cfg_ready;
            @(posedge clk);
        end
        while (!hs);
        cfg_valid <= 1'b0;
        cur_limit = v;
    endtask

    task automatic send_chunk(input logic [31:0] tag, input logic [31:0] seq, input int first,
                              input int len, input logic [31:0] ccrc, input int cut,
                              input logic mark_last);
        send(CMD_HEADER, tag, seq, '0, '0, len[7:0], ccrc, '0, 1'b0);
        for (int i = 0; i < cut; i++)
            send(CMD_PAYLOAD, tag, $urandom(), '0, '0, '0, '0, image[first + i],
                 (i == cut - 1) && mark_last);
    endtask

    task automatic run_session();
        logic [31:0] tag;
        logic [31:0] seq;
        logic [31:0] icrc;
        logic [31:0] ccrc;
        int size;
        int done;
        int len;
        int cap;
        int mode;
        tag = $urandom();
        size = ($urandom_range(19) == 0) ? 250 : $urandom_range(1, 120);
        if (size > cur_limit)
            size = cur_limit;
        if ($urandom_range(24) == 0)
            size = cur_limit + 1;
        for (int i = 0; i < size && i < 256; i++)
            image[i] = 8'($urandom());
        icrc = crc_over(32'hFFFFFFFF, 0, (size > 256) ? 256 : size) ^ 32'hFFFFFFFF;
        if ($urandom_range(9) == 0)
            icrc = $urandom();
        send(CMD_BEGIN, tag, $urandom(), size[24:0], icrc, 8'($urandom()), $urandom(),
             8'($urandom()), 1'b0);
        if (size > cur_limit)
            return;
        seq = '0;
        done = 0;
        while (done < size)
        begin
            cap = (size > 120) ? 200 : 24;
            if (cap > size - done)
                cap = size - done;
            len = $urandom_range(1, cap);
            ccrc = crc_over(32'hFFFFFFFF, done, len) ^ 32'hFFFFFFFF;
            mode = $urandom_range(11);
            case (mode)
                0: send_chunk(tag, seq, done, len, ccrc ^ (32'd1 << $urandom_range(31)),
                              len, 1'($urandom_range(1)));
                1: send_chunk(tag, seq, done, len + 1, ccrc, len, 1'b1);
                2: send(CMD_BEGIN, tag, '0, 25'($urandom()), $urandom(), '0, '0, '0, 1'b0);
                3: send(CMD_HEADER, tag, seq + $urandom_range(1, 3), '0, '0, len[7:0], ccrc,
                        '0, 1'b0);
                4:
                begin
                    send_chunk(tag, seq, done, len, ccrc, $urandom_range(0, len - 1), 1'b0);
                    send(CMD_END, tag, seq, '0, '0, '0, '0, '0, 1'b0);
                end
                5:
                begin
                    if (seq != 0)
                        send(CMD_HEADER, tag, seq - 32'd1, '0, '0, len[7:0], ccrc, '0, 1'b0);
                    send_noise(tag);
                end
                default:
                begin
                    send_chunk(tag, seq, done, len, ccrc, len, 1'($urandom_range(1)));
                    done += len;
                    seq++;
                end
            endcase
            if ($urandom_range(59) == 0)
            begin
                send(CMD_ABORT, tag, $urandom(), '0, '0, '0, '0, '0, 1'b0);
                return;
            end
        end
        send(CMD_END, tag, seq, '0, '0, '0, '0, '0, 1'b0);
    endtask

    initial
    begin
        #50_000_000;
        $display("** firmware_update_session_receiver_unit: FAILED **");
        $finish;
    end

    initial
    begin
        logic [31:0] t;
        logic [31:0] c;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, first with the default partition limit, then with limits of 1 and 0x1000000.
        t = 32'hFFFFFFFF;
        send(CMD_BEGIN, t, '0, 25'd0, '0, '0, '0, '0, 1'b0);
        send(CMD_BEGIN, t, '0, 25'd1048577, '0, '0, '0, '0, 1'b0);
        send(CMD_PAYLOAD, t, '0, '0, '0, '0, '0, 8'hFF, 1'b1);
        send(command_t'(3'd5), t, '0, '0, '0, '0, '0, '0, 1'b0);
        send(command_t'(3'd6), t, '0, '0, '0, '0, '0, '0, 1'b0);
        send(command_t'(3'd7), t, '0, '0, '0, '0, '0, '0, 1'b0);
        send(CMD_HEADER, t, '0, '0, '0, 8'd1, '0, '0, 1'b0);
        send(CMD_END, t, 32'hFFFFFFFF, '0, '0, '0, '0, '0, 1'b0);
        image[0] = 8'hFF;
        image[1] = 8'h00;
        image[2] = 8'h5A;
        c = crc_over(32'hFFFFFFFF, 0, 3) ^ 32'hFFFFFFFF;
        send(CMD_BEGIN, t, '0, 25'd3, c, '0, '0, '0, 1'b0);
        send(CMD_BEGIN, t, '0, 25'd7, '0, '0, '0, '0, 1'b0);
        send(CMD_HEADER, t, 32'hFFFFFFFF, '0, '0, 8'd1, '0, '0, 1'b0);
        send(CMD_HEADER, t, '0, '0, '0, 8'd0, '0, '0, 1'b0);
        send(CMD_HEADER, t, '0, '0, '0, 8'd201, '0, '0, 1'b0);
        send(CMD_HEADER, t, '0, '0, '0, 8'd4, '0, '0, 1'b0);
        send_chunk(t, '0, 0, 2, crc_over(32'hFFFFFFFF, 0, 2) ^ 32'hFFFFFFFF, 2, 1'b1);
        send(CMD_END, t, 32'd1, '0, '0, '0, '0, '0, 1'b0);
        send(CMD_HEADER, t, '0, '0, '0, 8'd1, '0, '0, 1'b0);
        send_chunk(t, 32'd1, 2, 1, 32'h0, 1, 1'b1);
        send_chunk(t, 32'd1, 2, 1, crc_over(32'hFFFFFFFF, 2, 1) ^ 32'hFFFFFFFF, 1, 1'b0);
        send(CMD_END, t, 32'd2, '0, '0, '0, '0, '0, 1'b0);
        send(CMD_BEGIN, 32'h0, '0, 25'd5, '0, '0, '0, '0, 1'b0);
        send(CMD_ABORT, 32'h1, '0, '0, '0, '0, '0, '0, 1'b0);
        send(CMD_ABORT, 32'h0, '0, '0, '0, '0, '0, '0, 1'b0);
        send(CMD_END, 32'h0, '0, '0, '0, '0, '0, '0, 1'b0);

        set_limit(25'd1);
        send(CMD_BEGIN, t, '0, 25'd2, '0, '0, '0, '0, 1'b0);
        send(CMD_BEGIN, t, '0, 25'd1, '0, '0, '0, '0, 1'b0);
        set_limit(25'h1000000);
        send(CMD_BEGIN, t, '0, 25'h1000000, '0, '0, '0, '0, 1'b0);
        send(CMD_BEGIN, t, '0, 25'h1FFFFFF, '0, '0, '0, '0, 1'b0);

        // Random part in four phases, each with its own partition limit, idle and stall rates.
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: set_limit(25'h1000000);
                1: set_limit(25'd1);
                2: set_limit(25'($urandom_range(1, 300)));
                default: set_limit(PARTITION_LIMIT_RESET);
            endcase
            send_idle_pct = (ph == 1) ? 45 : (ph == 3) ? 21 : 0;
            recv_stall_pct = (ph == 2) ? 45 : (ph == 3) ? 21 : 0;
            while (items_sent < 60 + 250 * (ph + 1))
            begin
                repeat ($urandom_range(0, 3)) send_noise($urandom());
                run_session();
            end
        end

        drain();
        repeat (10) @(posedge clk);
        if (mismatches == 0 && acks_pending == 0)
            $display("** firmware_update_session_receiver_unit: PASSED **");
        else
            $display("** firmware_update_session_receiver_unit: FAILED **");
        $finish;
    end

endmodule
`default_nettype wire
